// ----- design/rsbb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rsbb_pkg;

  // Store geometry and fixed-point formats.
  localparam int SRC_MAX_WIDTH    = 256;
  localparam int SRC_MAX_HEIGHT   = 256;
  localparam int COORD_FRAC_BITS  = 16;
  localparam int WEIGHT_FRAC_BITS = 8;

  localparam int XW      = $clog2(SRC_MAX_WIDTH);
  localparam int YW      = $clog2(SRC_MAX_HEIGHT);
  localparam int BANK_AW = (XW - 1) + (YW - 1);
  localparam int ENT_W   = 25;
  localparam int COL_W   = 24;

  // Blend arithmetic.
  localparam int ALPHA_ONE = 256;
  localparam int ALPHA_W   = 9;
  localparam int ALPHA_SH  = 8;
  localparam int MIX_W     = 16;
  localparam int W_W       = 2 * WEIGHT_FRAC_BITS + 1;
  localparam int P_W       = MIX_W + W_W;
  localparam int SUM_W     = P_W + 2;
  localparam int OUT_SH    = ALPHA_SH + 2 * WEIGHT_FRAC_BITS;

  // Coordinate arithmetic.
  localparam int SZ_W    = 9;
  localparam int DELTA_W = 14;
  localparam int PROD_W  = DELTA_W + 24;
  localparam int T_W     = PROD_W + 2;
  localparam int IX_W    = T_W - 1 - COORD_FRAC_BITS;

  localparam int WSH_L = (COORD_FRAC_BITS >= WEIGHT_FRAC_BITS) ? 0
                                                               : WEIGHT_FRAC_BITS - COORD_FRAC_BITS;
  localparam int WSH_R = (COORD_FRAC_BITS >= WEIGHT_FRAC_BITS) ? COORD_FRAC_BITS - WEIGHT_FRAC_BITS
                                                               : 0;

  // Register map.
  typedef enum logic [2:0] {
    REG_COS   = 3'd0,
    REG_SIN   = 3'd1,
    REG_SRC_W = 3'd2,
    REG_SRC_H = 3'd3,
    REG_DST_W = 3'd4,
    REG_DST_H = 3'd5,
    REG_ALPHA = 3'd6,
    REG_KEY   = 3'd7
  } reg_idx_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_BLEND = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [23:0] cos_sc;
    logic signed [23:0] sin_sc;
    logic [SZ_W-1:0]    src_w;
    logic [SZ_W-1:0]    src_h;
    logic [11:0]        dst_w;
    logic [11:0]        dst_h;
    logic [ALPHA_W-1:0] alpha;
    logic [24:0]        key;
  } cfg_t;

  typedef struct packed {
    logic             blend;
    logic [11:0]      col;
    logic [11:0]      row;
    logic [COL_W-1:0] color;
  } item_t;

  // Result of the coordinate stages, one request in flight.
  typedef struct packed {
    logic                       valid;
    logic                       blend;
    logic                       in_src;
    logic                       load_ok;
    logic                       opaque;
    logic [COL_W-1:0]           color;
    logic [2:0][MIX_W-1:0]      bgm;
    logic [XW-1:0]              col;
    logic [YW-1:0]              row;
    logic [XW-1:0]              ix;
    logic [YW-1:0]              iy;
    logic [WEIGHT_FRAC_BITS-1:0] fx;
    logic [WEIGHT_FRAC_BITS-1:0] fy;
  } map_out_t;

  // Access to the banked source store.
  typedef struct packed {
    logic               we;
    logic [1:0]         wbank;
    logic [BANK_AW-1:0] waddr;
    logic [ENT_W-1:0]   wdata;
    logic               re;
    logic [XW-1:0]      ix;
    logic [YW-1:0]      iy;
  } store_req_t;

  function automatic logic [ALPHA_W-1:0] sat_alpha(input logic [ALPHA_W-1:0] a);
    sat_alpha = (int'(a) > ALPHA_ONE) ? ALPHA_W'(ALPHA_ONE) : a;
  endfunction

  function automatic logic [WEIGHT_FRAC_BITS-1:0] weight_frac(
    input logic [COORD_FRAC_BITS-1:0] f
  );
    logic [COORD_FRAC_BITS+WEIGHT_FRAC_BITS-1:0] t;
    t = {{WEIGHT_FRAC_BITS{1'b0}}, f};
    t = (t << WSH_L) >> WSH_R;
    weight_frac = t[WEIGHT_FRAC_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/rsbb_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsbb_cfg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output rsbb_pkg::cfg_t    cfg_o
);

  rsbb_pkg::cfg_t      cfg_q;
  rsbb_pkg::reg_idx_e  idx;
  logic                wr;

  assign pready = 1'b1;
  assign idx    = rsbb_pkg::reg_idx_e'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // Register writes on the access phase of a write request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_sc <= 24'sd65536;
      cfg_q.sin_sc <= 24'sd0;
      cfg_q.src_w  <= 9'd256;
      cfg_q.src_h  <= 9'd256;
      cfg_q.dst_w  <= 12'd256;
      cfg_q.dst_h  <= 12'd256;
      cfg_q.alpha  <= 9'd256;
      cfg_q.key    <= 25'h1FFFFFF;
    end else if (wr) begin
      unique case (idx)
        rsbb_pkg::REG_COS:   cfg_q.cos_sc <= pwdata[23:0];
        rsbb_pkg::REG_SIN:   cfg_q.sin_sc <= pwdata[23:0];
        rsbb_pkg::REG_SRC_W: cfg_q.src_w  <= pwdata[8:0];
        rsbb_pkg::REG_SRC_H: cfg_q.src_h  <= pwdata[8:0];
        rsbb_pkg::REG_DST_W: cfg_q.dst_w  <= pwdata[11:0];
        rsbb_pkg::REG_DST_H: cfg_q.dst_h  <= pwdata[11:0];
        rsbb_pkg::REG_ALPHA: cfg_q.alpha  <= pwdata[8:0];
        rsbb_pkg::REG_KEY:   cfg_q.key    <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    unique case (idx)
      rsbb_pkg::REG_COS:   prdata = {8'd0, cfg_q.cos_sc};
      rsbb_pkg::REG_SIN:   prdata = {8'd0, cfg_q.sin_sc};
      rsbb_pkg::REG_SRC_W: prdata = {23'd0, cfg_q.src_w};
      rsbb_pkg::REG_SRC_H: prdata = {23'd0, cfg_q.src_h};
      rsbb_pkg::REG_DST_W: prdata = {20'd0, cfg_q.dst_w};
      rsbb_pkg::REG_DST_H: prdata = {20'd0, cfg_q.dst_h};
      rsbb_pkg::REG_ALPHA: prdata = {23'd0, cfg_q.alpha};
      rsbb_pkg::REG_KEY:   prdata = {7'd0, cfg_q.key};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/rsbb_map.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsbb_map (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              in_valid_i,
  input  wire rsbb_pkg::item_t   in_item_i,
  input  wire rsbb_pkg::cfg_t    cfg_i,
  output rsbb_pkg::map_out_t     map_o
);

  localparam int DW = rsbb_pkg::DELTA_W;
  localparam int PW = rsbb_pkg::PROD_W;
  localparam int TW = rsbb_pkg::T_W;
  localparam int CF = rsbb_pkg::COORD_FRAC_BITS;
  localparam int IW = rsbb_pkg::IX_W;
  localparam int SW = rsbb_pkg::SZ_W;

  logic [SW-1:0]          w, h, px, py;
  logic signed [DW-1:0]   diff_x, diff_y, rnd_x, rnd_y, cx, cy, dxs, dys;
  logic                   opaque;
  logic [rsbb_pkg::ALPHA_W-1:0] alpha;

  logic                   s1_v_q;
  rsbb_pkg::item_t        s1_item_q;
  logic                   s1_opq_q;
  logic signed [DW-1:0]   s1_dx_q, s1_dy_q;

  logic                   s2_v_q;
  rsbb_pkg::item_t        s2_item_q;
  logic                   s2_opq_q;
  logic signed [PW-1:0]   s2_xc_q, s2_ys_q, s2_xs_q, s2_yc_q;
  logic [2:0][rsbb_pkg::MIX_W-1:0] s2_bgm_q;

  logic signed [TW-1:0]   tx, ty, pxs, pys;
  logic [IW-1:0]          ixf, iyf;
  logic                   in_x, in_y;

  rsbb_pkg::map_out_t     s3_q;

  // Clipped source size and centre offsets.
  always_comb begin
    w  = (int'(cfg_i.src_w) > rsbb_pkg::SRC_MAX_WIDTH)
           ? SW'(rsbb_pkg::SRC_MAX_WIDTH) : cfg_i.src_w;
    h  = (int'(cfg_i.src_h) > rsbb_pkg::SRC_MAX_HEIGHT)
           ? SW'(rsbb_pkg::SRC_MAX_HEIGHT) : cfg_i.src_h;
    px = w >> 1;
    py = h >> 1;
    diff_x = $signed(DW'(cfg_i.dst_w)) - $signed(DW'(w));
    diff_y = $signed(DW'(cfg_i.dst_h)) - $signed(DW'(h));
    // Arithmetic halving rounds down, so negative values are nudged up first to round toward zero.
    rnd_x  = diff_x + $signed({{(DW-1){1'b0}}, diff_x[DW-1]});
    rnd_y  = diff_y + $signed({{(DW-1){1'b0}}, diff_y[DW-1]});
    cx     = rnd_x >>> 1;
    cy     = rnd_y >>> 1;
    dxs    = $signed(DW'(in_item_i.col)) - cx - $signed(DW'(px));
    dys    = $signed(DW'(in_item_i.row)) - cy - $signed(DW'(py));
    opaque = cfg_i.key[24] || (in_item_i.color != cfg_i.key[23:0]);
    alpha  = rsbb_pkg::sat_alpha(cfg_i.alpha);
  end

  // Stage one: offsets from the centre and the key test.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv_i) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_item_q <= in_item_i;
      s1_opq_q  <= opaque;
      s1_dx_q   <= dxs;
      s1_dy_q   <= dys;
    end
  end

  // Stage two: the four rotation products and the background share.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv_i) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_item_q <= s1_item_q;
      s2_opq_q  <= s1_opq_q;
      s2_xc_q   <= s1_dx_q * cfg_i.cos_sc;
      s2_ys_q   <= s1_dy_q * cfg_i.sin_sc;
      s2_xs_q   <= s1_dx_q * cfg_i.sin_sc;
      s2_yc_q   <= s1_dy_q * cfg_i.cos_sc;
      for (int c = 0; c < 3; c++) begin
        s2_bgm_q[c] <= rsbb_pkg::MIX_W'(s1_item_q.color[8*c +: 8])
                     * rsbb_pkg::MIX_W'(rsbb_pkg::ALPHA_W'(rsbb_pkg::ALPHA_ONE) - alpha);
      end
    end
  end

  // Source coordinate, floor and bounds.
  always_comb begin
    pxs  = $signed(TW'(px) << CF);
    pys  = $signed(TW'(py) << CF);
    tx   = s2_xc_q - s2_ys_q + pxs;
    ty   = s2_xs_q + s2_yc_q + pys;
    ixf  = tx[TW-2:CF];
    iyf  = ty[TW-2:CF];
    in_x = !tx[TW-1] && (({1'b0, ixf} + (IW+1)'(1)) < (IW+1)'(w));
    in_y = !ty[TW-1] && (({1'b0, iyf} + (IW+1)'(1)) < (IW+1)'(h));
  end

  // Stage three: neighbour position and weights.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (adv_i) begin
      s3_q.valid   <= s2_v_q;
      s3_q.blend   <= s2_item_q.blend;
      s3_q.in_src  <= in_x && in_y;
      s3_q.load_ok <= (int'(s2_item_q.col) < rsbb_pkg::SRC_MAX_WIDTH)
                   && (int'(s2_item_q.row) < rsbb_pkg::SRC_MAX_HEIGHT);
      s3_q.opaque  <= s2_opq_q;
      s3_q.color   <= s2_item_q.color;
      s3_q.bgm     <= s2_bgm_q;
      s3_q.col     <= s2_item_q.col[rsbb_pkg::XW-1:0];
      s3_q.row     <= s2_item_q.row[rsbb_pkg::YW-1:0];
      s3_q.ix      <= ixf[rsbb_pkg::XW-1:0];
      s3_q.iy      <= iyf[rsbb_pkg::YW-1:0];
      s3_q.fx      <= rsbb_pkg::weight_frac(tx[CF-1:0]);
      s3_q.fy      <= rsbb_pkg::weight_frac(ty[CF-1:0]);
    end
  end

  assign map_o = s3_q;

endmodule

`default_nettype wire

// ----- design/rsbb_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsbb_store (
  input  wire logic                 clk_i,
  input  wire rsbb_pkg::store_req_t req_i,
  output logic [3:0][rsbb_pkg::ENT_W-1:0] rd_o
);

  localparam int XW    = rsbb_pkg::XW;
  localparam int YW    = rsbb_pkg::YW;
  localparam int DEPTH = 1 << rsbb_pkg::BANK_AW;

  logic [XW-1:0] ix1;
  logic [YW-1:0] iy1;

  assign ix1 = req_i.ix + XW'(1);
  assign iy1 = req_i.iy + YW'(1);

  // Four banks split by row and column parity, so the 2x2 window reads
  // exactly one entry from each bank.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [rsbb_pkg::ENT_W-1:0]   mem [DEPTH];
    logic [XW-2:0]                xa;
    logic [YW-2:0]                ya;
    logic [rsbb_pkg::ENT_W-1:0]   rd_q;

    assign xa = b[0] ? req_i.ix[XW-1:1] : ix1[XW-1:1];
    assign ya = b[1] ? req_i.iy[YW-1:1] : iy1[YW-1:1];

    always_ff @(posedge clk_i) begin
      if (req_i.we && (req_i.wbank == 2'(b))) begin
        mem[req_i.waddr] <= req_i.wdata;
      end
      if (req_i.re) begin
        rd_q <= mem[{ya, xa}];
      end
    end

    assign rd_o[b] = rd_q;
  end

endmodule

`default_nettype wire

// ----- design/rsbb_blend.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rsbb_blend (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  adv_i,
  input  wire rsbb_pkg::map_out_t    map_i,
  input  wire logic [3:0][rsbb_pkg::ENT_W-1:0] rd_i,
  input  wire logic [rsbb_pkg::ALPHA_W-1:0]    alpha_i,
  output logic                       out_valid_o,
  output logic [23:0]                out_color_o,
  output logic                       covered_o
);

  localparam int WF = rsbb_pkg::WEIGHT_FRAC_BITS;
  localparam int MW = rsbb_pkg::MIX_W;
  localparam int WW = rsbb_pkg::W_W;
  localparam int PW = rsbb_pkg::P_W;
  localparam int SM = rsbb_pkg::SUM_W;

  // Stage four: travels alongside the store read.
  logic                  s4_v_q, s4_blend_q, s4_in_q, s4_ix0_q, s4_iy0_q;
  logic [23:0]           s4_color_q;
  logic [2:0][MW-1:0]    s4_bgm_q;
  logic [WF-1:0]         s4_fx_q, s4_fy_q;

  // Stage five: per-neighbour blended channels and weights.
  logic                  s5_v_q, s5_blend_q, s5_in_q;
  logic [23:0]           s5_color_q;
  logic [3:0][2:0][MW-1:0] s5_mix_q;
  logic [3:0][WW-1:0]    s5_wt_q;

  // Stage six: weighted products.
  logic                  s6_v_q, s6_blend_q, s6_in_q;
  logic [23:0]           s6_color_q;
  logic [3:0][2:0][PW-1:0] s6_prod_q;

  // Output register.
  logic                  out_v_q, cov_q;
  logic [23:0]           out_col_q;

  logic [3:0][rsbb_pkg::ENT_W-1:0] ent;
  logic [3:0][2:0][MW-1:0] mix;
  logic [WF:0]           sfx, sfy, fx, fy;
  logic [3:0][WW-1:0]    wt;
  logic [SM-1:0]         sum;
  logic [SM-1:0]         shr;
  logic [23:0]           res;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv_i) begin
      s4_v_q  <= map_i.valid;
      s5_v_q  <= s4_v_q;
      s6_v_q  <= s5_v_q;
      out_v_q <= s6_v_q && s6_blend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s4_blend_q <= map_i.blend;
      s4_in_q    <= map_i.in_src;
      s4_ix0_q   <= map_i.ix[0];
      s4_iy0_q   <= map_i.iy[0];
      s4_color_q <= map_i.color;
      s4_bgm_q   <= map_i.bgm;
      s4_fx_q    <= map_i.fx;
      s4_fy_q    <= map_i.fy;
    end
  end

  // Pick each neighbour from its bank, blend it over the background.
  always_comb begin
    fx  = {1'b0, s4_fx_q};
    fy  = {1'b0, s4_fy_q};
    sfx = (WF+1)'(1 << WF) - fx;
    sfy = (WF+1)'(1 << WF) - fy;
    wt[0] = WW'(sfx) * WW'(sfy);
    wt[1] = WW'(fx)  * WW'(sfy);
    wt[2] = WW'(sfx) * WW'(fy);
    wt[3] = WW'(fx)  * WW'(fy);
    for (int k = 0; k < 4; k++) begin
      ent[k] = rd_i[{s4_iy0_q ^ k[1], s4_ix0_q ^ k[0]}];
      for (int c = 0; c < 3; c++) begin
        if (ent[k][24]) begin
          mix[k][c] = MW'(ent[k][8*c +: 8]) * MW'(alpha_i) + s4_bgm_q[c];
        end else begin
          mix[k][c] = MW'(s4_color_q[8*c +: 8]) << rsbb_pkg::ALPHA_SH;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s5_blend_q <= s4_blend_q;
      s5_in_q    <= s4_in_q;
      s5_color_q <= s4_color_q;
      s5_mix_q   <= mix;
      s5_wt_q    <= wt;
    end
  end

  // Weighting.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s6_blend_q <= s5_blend_q;
      s6_in_q    <= s5_in_q;
      s6_color_q <= s5_color_q;
      for (int k = 0; k < 4; k++) begin
        for (int c = 0; c < 3; c++) begin
          s6_prod_q[k][c] <= PW'(s5_mix_q[k][c]) * PW'(s5_wt_q[k]);
        end
      end
    end
  end

  // Sum, truncate and clamp each channel.
  always_comb begin
    res = '0;
    sum = '0;
    shr = '0;
    for (int c = 0; c < 3; c++) begin
      sum = SM'(s6_prod_q[0][c]) + SM'(s6_prod_q[1][c])
          + SM'(s6_prod_q[2][c]) + SM'(s6_prod_q[3][c]);
      shr = sum >> rsbb_pkg::OUT_SH;
      res[8*c +: 8] = (shr > SM'(8'hFF)) ? 8'hFF : shr[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cov_q     <= s6_in_q;
      out_col_q <= s6_in_q ? res : s6_color_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_color_o = out_col_q;
  assign covered_o   = cov_q;

endmodule

`default_nettype wire

// ----- design/rotate_scale_bilinear_blend.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Rotating, scaling bilinear blender. Load requests (operation 0) write one
// source pixel and its colour-key opacity bit into a 256 x 256 store; blend
// requests (operation 1) map one destination pixel back into the source,
// blend the four neighbours over the background colour and return one result
// with the covered flag. The block takes one request per clock while the output
// is not held and returns one blend result per blend request; a load returns
// nothing. The rate comes from a seven-stage pipeline and a store split into
// four banks by row and column parity, so the whole 2x2 window is read in the
// same cycle. The store is not cleared at reset: blend only over pixels that
// have been loaded. Write the registers only while no request is in flight. A
// held result stalls the whole pipeline and the input.
module rotate_scale_bilinear_blend (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [11:0] column_i,
  input  wire logic [11:0] row_i,
  input  wire logic [23:0] pixel_color_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [23:0]      out_color_o,
  output logic             covered_o
);

  rsbb_pkg::cfg_t        cfg;
  rsbb_pkg::item_t       item;
  rsbb_pkg::map_out_t    map;
  rsbb_pkg::store_req_t  st_req;
  logic [3:0][rsbb_pkg::ENT_W-1:0] rd;
  logic                  adv;

  // The pipeline moves unless a result is held at the output.
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  assign item.blend = (rsbb_pkg::op_e'(operation_i) == rsbb_pkg::OP_BLEND);
  assign item.col   = column_i;
  assign item.row   = row_i;
  assign item.color = pixel_color_i;

  rsbb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rsbb_map u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .in_item_i  (item),
    .cfg_i      (cfg),
    .map_o      (map)
  );

  // Loads write and blends read at the same stage, so order is kept.
  always_comb begin
    st_req.we    = adv && map.valid && !map.blend && map.load_ok;
    st_req.wbank = {map.row[0], map.col[0]};
    st_req.waddr = {map.row[rsbb_pkg::YW-1:1], map.col[rsbb_pkg::XW-1:1]};
    st_req.wdata = {map.opaque, map.color};
    st_req.re    = adv && map.valid && map.blend && map.in_src;
    st_req.ix    = map.ix;
    st_req.iy    = map.iy;
  end

  rsbb_store u_store (
    .clk_i (clk_i),
    .req_i (st_req),
    .rd_o  (rd)
  );

  rsbb_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .map_i       (map),
    .rd_i        (rd),
    .alpha_i     (rsbb_pkg::sat_alpha(cfg.alpha)),
    .out_valid_o (out_valid_o),
    .out_color_o (out_color_o),
    .covered_o   (covered_o)
  );

  // A held result must hold back new requests.
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while result held");

  // A single request never both writes and reads the store.
  a_store_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_req.we && st_req.re))
    else $error("store written and read by one request");

  // A held result is still offered in the next cycle.
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_color_o)))
    else $error("held result lost");

endmodule

`default_nettype wire

// ----- test/tb_rotate_scale_bilinear_blend.sv -----
`timescale 1ns / 1ps

module tb_rotate_scale_bilinear_blend;
  import rsbb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op_in = 1'b0;
  logic [11:0] col_in = '0;
  logic [11:0] row_in = '0;
  logic [23:0] color_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] out_color;
  logic        covered;

  rotate_scale_bilinear_blend uut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .operation_i(op_in), .column_i(col_in), .row_i(row_in), .pixel_color_i(color_in),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_color_o(out_color), .covered_o(covered)
  );

  always #5 clk = ~clk;

  // Mirror of the register file and the source store.
  longint      m_cos = 65536;
  longint      m_sin = 0;
  longint      m_src_w = 256;
  longint      m_src_h = 256;
  longint      m_dst_w = 256;
  longint      m_dst_h = 256;
  longint      m_alpha = 256;
  longint      m_key = -1;
  logic [24:0] pixel_mirror [0:65535];

  typedef struct {
    logic [23:0] color;
    logic        cov;
  } blend_result_t;

  blend_result_t pending_blends[$];

  int fails = 0;
  int n_loads = 0;
  int n_blends = 0;
  int n_covered = 0;
  int n_results = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int hold_left = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fails++;
  endtask

  // Expected outcome of one blend request under the current registers.
  function automatic blend_result_t predict_blend(input longint col, input longint row,
                                                  input logic [23:0] bg);
    blend_result_t r;
    longint w, h, px, py, cx, cy, dx, dy, tx, ty, ix, iy, a, fx, fy;
    longint wt[4];
    logic [24:0] e[4];
    longint avk, acc, mix;
    w = (m_src_w > 256) ? 256 : m_src_w;
    h = (m_src_h > 256) ? 256 : m_src_h;
    px = w / 2;
    py = h / 2;
    cx = (m_dst_w - w) / 2;
    cy = (m_dst_h - h) / 2;
    dx = col - cx - px;
    dy = row - cy - py;
    tx = dx * m_cos - dy * m_sin + px * 65536;
    ty = dx * m_sin + dy * m_cos + py * 65536;
    r.color = bg;
    r.cov = 1'b0;
    if (tx < 0 || ty < 0) return r;
    ix = tx >>> 16;
    iy = ty >>> 16;
    if (!(ix + 1 < w && iy + 1 < h)) return r;
    a = (m_alpha > 256) ? 256 : m_alpha;
    fx = (tx & 65535) >> 8;
    fy = (ty & 65535) >> 8;
    wt[0] = (256 - fx) * (256 - fy);
    wt[1] = fx * (256 - fy);
    wt[2] = (256 - fx) * fy;
    wt[3] = fx * fy;
    e[0] = pixel_mirror[iy * 256 + ix];
    e[1] = pixel_mirror[iy * 256 + ix + 1];
    e[2] = pixel_mirror[(iy + 1) * 256 + ix];
    e[3] = pixel_mirror[(iy + 1) * 256 + ix + 1];
    for (int sh = 0; sh < 24; sh += 8) begin
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        avk = e[k][24] ? a : 0;
        mix = longint'((e[k] >> sh) & 25'hFF) * avk + longint'((bg >> sh) & 24'hFF) * (256 - avk);
        acc += mix * wt[k];
      end
      acc = acc >> 24;
      if (acc > 255) acc = 255;
      r.color[sh +: 8] = acc[7:0];
    end
    r.cov = 1'b1;
    return r;
  endfunction

  // Register write over the APB port, mirrored into the predictor.
  task automatic write_reg(input reg_idx_e idx, input longint value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value[31:0];
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_COS:   m_cos = longint'($signed(value[23:0]));
      REG_SIN:   m_sin = longint'($signed(value[23:0]));
      REG_SRC_W: m_src_w = value & 511;
      REG_SRC_H: m_src_h = value & 511;
      REG_DST_W: m_dst_w = value & 4095;
      REG_DST_H: m_dst_h = value & 4095;
      REG_ALPHA: m_alpha = value & 511;
      REG_KEY:   m_key = longint'($signed(value[24:0]));
      default: ;
    endcase
  endtask

  // Offer one request and hold it until accepted; the mirror is updated on acceptance.
  task automatic send_request(input op_e op, input logic [11:0] col, input logic [11:0] row,
                              input logic [23:0] color);
    @(negedge clk);
    in_valid = 1'b1;
    op_in = op;
    col_in = col;
    row_in = row;
    color_in = color;
    do @(posedge clk); while (in_stall);
    if (op == OP_LOAD) begin
      n_loads++;
      if (col < 256 && row < 256)
        pixel_mirror[row * 256 + col] = {(m_key < 0 || longint'(color) != m_key), color};
    end else begin
      n_blends++;
      pending_blends.push_back(predict_blend(col, row, color));
    end
  endtask

  // Sender burst pacing: after a burst, drop valid for a random gap.
  task automatic pace_sender(input bit bursty);
    if (!bursty) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 12);
    @(negedge clk);
    in_valid = 1'b0;
    repeat ($urandom_range(0, 6)) @(negedge clk);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_blends.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic load_pixel(input logic [11:0] col, input logic [11:0] row, input bit bursty);
    logic [23:0] c;
    c = ($urandom_range(0, 4) == 0 && m_key >= 0) ? m_key[23:0] : 24'($urandom);
    send_request(OP_LOAD, col, row, c);
    pace_sender(bursty);
  endtask

  task automatic blend_pixel(input bit bursty);
    logic [11:0] col, row;
    if ($urandom_range(0, 9) == 0) begin
      col = 12'($urandom);
      row = 12'($urandom);
    end else begin
      col = 12'($urandom_range(0, int'(m_dst_w) + 8));
      row = 12'($urandom_range(0, int'(m_dst_h) + 8));
    end
    send_request(OP_BLEND, col, row, 24'($urandom));
    pace_sender(bursty);
  endtask

  // Mixed random traffic: mostly blends, some loads, some outside the store.
  task automatic random_traffic(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 7) == 0)
          load_pixel(12'($urandom_range(0, 300)), 12'($urandom_range(0, 300)), 1'b1);
        else
          load_pixel(12'($urandom_range(0, 11)), 12'($urandom_range(0, 11)), 1'b1);
      end else begin
        blend_pixel(1'b1);
      end
    end
    drain();
  endtask

  // A 12 x 12 corner of the store is written; every source pixel read later lies in it.
  task automatic test_fill_store;
    write_reg(REG_KEY, 24'h00FF00);
    for (int r = 0; r < 12; r++)
      for (int c = 0; c < 12; c++)
        load_pixel(12'(c), 12'(r), 1'b0);
    load_pixel(12'd4095, 12'd0, 1'b0);
    load_pixel(12'd0, 12'd4095, 1'b0);
    load_pixel(12'd256, 12'd256, 1'b0);
    drain();
  endtask

  // Field extremes and the corner cases of the mapping.
  task automatic test_directed;
    write_reg(REG_COS, 65536);
    write_reg(REG_SIN, 0);
    write_reg(REG_SRC_W, 12);
    write_reg(REG_SRC_H, 12);
    write_reg(REG_DST_W, 12);
    write_reg(REG_DST_H, 12);
    write_reg(REG_ALPHA, 256);
    send_request(OP_BLEND, 12'd0, 12'd0, 24'h000000);
    send_request(OP_BLEND, 12'd10, 12'd10, 24'hFFFFFF);
    send_request(OP_BLEND, 12'd11, 12'd0, 24'hABCDEF);
    send_request(OP_BLEND, 12'd4095, 12'd4095, 24'hFFFFFF);
    send_request(OP_BLEND, 12'd100, 12'd4095, 24'h555555);
    drain();
    // Fractional position with half opacity.
    write_reg(REG_COS, 32768 + 4321);
    write_reg(REG_ALPHA, 128);
    send_request(OP_BLEND, 12'd8, 12'd9, 24'h123456);
    send_request(OP_BLEND, 12'd3, 12'd2, 24'hAAAAAA);
    drain();
    // Alpha over range, and a destination wider than the source so that
    // low coordinates map below zero.
    write_reg(REG_ALPHA, 300);
    write_reg(REG_DST_W, 4095);
    write_reg(REG_DST_H, 1);
    send_request(OP_BLEND, 12'd0, 12'd0, 24'h0F0F0F);
    send_request(OP_BLEND, 12'd2047, 12'd0, 24'hF0F0F0);
    send_request(OP_BLEND, 12'd1990, 12'd0, 24'h00FF00);
    drain();
    // Oversized and minimal source sizes.
    write_reg(REG_SRC_W, 511);
    write_reg(REG_SRC_H, 1);
    write_reg(REG_DST_W, 300);
    write_reg(REG_DST_H, 300);
    send_request(OP_BLEND, 12'd150, 12'd150, 24'h808080);
    drain();
    write_reg(REG_SRC_H, 511);
    write_reg(REG_ALPHA, 0);
    write_reg(REG_COS, 65536);
    send_request(OP_BLEND, 12'd25, 12'd27, 24'h808080);
    send_request(OP_BLEND, 12'd30, 12'd24, 24'h7F7F7F);
    drain();
  endtask

  // Random traffic over a sweep of rotations, sizes and keys.
  task automatic test_random_settings;
    longint c, s;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin c = 65536; s = 0; end
        1: begin c = -8388608; s = 8388607; end
        2: begin c = 8388607; s = -8388608; end
        default: begin
          c = longint'($urandom_range(0, 262144)) - 131072;
          s = longint'($urandom_range(0, 262144)) - 131072;
        end
      endcase
      write_reg(REG_COS, c & 24'hFFFFFF);
      write_reg(REG_SIN, s & 24'hFFFFFF);
      write_reg(REG_SRC_W, (p == 0) ? 12 : $urandom_range(1, 12));
      write_reg(REG_SRC_H, (p == 0) ? 12 : $urandom_range(1, 12));
      write_reg(REG_DST_W, $urandom_range(1, 40));
      write_reg(REG_DST_H, $urandom_range(1, 40));
      write_reg(REG_ALPHA, (p == 3) ? 0 : $urandom_range(0, 300));
      case (p % 3)
        0: write_reg(REG_KEY, 25'h1FFFFFF);
        1: write_reg(REG_KEY, 24'hFFFFFF);
        default: write_reg(REG_KEY, $urandom_range(0, 24'hFFFFFF));
      endcase
      stall_mode = p % 3;
      random_traffic(25);
    end
    stall_mode = 0;
  endtask

  // Long receiver hold while the sender keeps offering blends back to back.
  task automatic test_backpressure;
    write_reg(REG_COS, 65536);
    write_reg(REG_SIN, 0);
    write_reg(REG_SRC_W, 12);
    write_reg(REG_SRC_H, 12);
    write_reg(REG_DST_W, 12);
    write_reg(REG_DST_H, 12);
    write_reg(REG_ALPHA, 200);
    @(posedge clk);
    hold_left = 300;
    for (int i = 0; i < 20; i++) blend_pixel(1'b0);
    drain();
  endtask

  // Receiver stall pattern, with a counted long hold on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      case (stall_mode)
        1: out_stall = ($urandom_range(0, 9) < 3);
        2: out_stall = ($urandom_range(0, 9) < 7);
        default: out_stall = 1'b0;
      endcase
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_blends.size() == 0) begin
        report_mismatch("result with no blend request outstanding");
      end else begin
        blend_result_t e;
        e = pending_blends.pop_front();
        if (out_color !== e.color)
          report_mismatch($sformatf("out_color %h, expected %h", out_color, e.color));
        if (covered !== e.cov)
          report_mismatch($sformatf("covered %b, expected %b", covered, e.cov));
        if (e.cov) n_covered++;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("Timeout with %0d results outstanding", pending_blends.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_fill_store();
    test_directed();
    test_random_settings();
    test_backpressure();
    stall_mode = 1;
    random_traffic(20);
    repeat (20) @(posedge clk);
    if (pending_blends.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_blends.size()));
    $display("Covered %0d loads and %0d blends (%0d inside the source) over eight settings,",
             n_loads, n_blends, n_covered);
    $display("with output stalls, a long receiver hold and %0d mismatches.", fails);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/rsbb_pkg.sv
design/rsbb_cfg.sv
design/rsbb_map.sv
design/rsbb_store.sv
design/rsbb_blend.sv
design/rotate_scale_bilinear_blend.sv
test/tb_rotate_scale_bilinear_blend.sv
